FILE: hdl/lpdp_pkg.sv
`default_nettype none

package lpdp_pkg;

  localparam int FRAC_BITS = 16;

  localparam int WORD_W  = 32;
  localparam int PROD_W  = 2 * WORD_W;
  // a row is the sum of four shifted products
  localparam int ROW_W   = PROD_W - FRAC_BITS + 2;
  // wide enough for rows, width*depth products and the limits, plus a sign
  localparam int CMP_W   = PROD_W + 2;
  localparam int Q_W     = 16;
  localparam int DIV_W   = Q_W + WORD_W;
  localparam int DIV_STG = Q_W;
  // products, rows, bounds, hit/divider setup, then one stage per quotient bit
  localparam int NSTG    = 4 + DIV_STG;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int IN_DATA_W  = 4 * WORD_W;
  localparam int OUT_DATA_W = 2 * Q_W + WORD_W;

  typedef enum logic [2:0] {
    REG_ROW0_LO,
    REG_ROW0_HI,
    REG_ROW1_LO,
    REG_ROW1_HI,
    REG_ROW2_LO,
    REG_ROW2_HI,
    REG_DIST_LIMITS,
    REG_IMAGE_SIZE
  } reg_idx_t;

  typedef logic [NSTG-1:0]         stg_mask_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ROW_W-1:0]  row_t;
  typedef logic signed [CMP_W-1:0]  cmp_t;

  function automatic prod_t smul(input logic signed [WORD_W-1:0] a,
                                 input logic signed [WORD_W-1:0] b);
    return a * b;
  endfunction

  // arithmetic shift floors each product before the row sum
  function automatic row_t row_sum(input prod_t p0, input prod_t p1,
                                   input prod_t p2, input prod_t p3);
    prod_t s0;
    prod_t s1;
    prod_t s2;
    prod_t s3;
    s0 = p0 >>> FRAC_BITS;
    s1 = p1 >>> FRAC_BITS;
    s2 = p2 >>> FRAC_BITS;
    s3 = p3 >>> FRAC_BITS;
    return ROW_W'(s0) + ROW_W'(s1) + ROW_W'(s2) + ROW_W'(s3);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lidar_point_depth_projector_core.sv
// pipeline: 20 register stages, which a point accepted at the input passes in order before
// it is on m_tdata; a stalled output only holds the stages behind it that are full
// throughput: one point per cycle unless the output stalls, and bubbles still close up;
// the stages are four arithmetic stages and a 16-stage restoring divider (one quotient
// bit per stage, column and row side by side)
// reset: synchronous active-high rst empties the pipeline and zeroes the config registers
`default_nettype none

module lidar_point_depth_projector_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // apb configuration
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [lpdp_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [lpdp_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic      [lpdp_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                      pready,
  // point stream
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // point_x, point_y, point_z, point_w
  input  wire logic [lpdp_pkg::IN_DATA_W-1:0]       s_tdata,
  // result stream
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // pixel_column, pixel_row, pixel_depth
  output logic      [lpdp_pkg::OUT_DATA_W-1:0]      m_tdata,
  // hit
  output logic                                      m_tuser
);

  localparam int W   = lpdp_pkg::WORD_W;
  localparam int DS  = lpdp_pkg::DIV_STG;
  localparam int DW  = lpdp_pkg::DIV_W;
  localparam int QW  = lpdp_pkg::Q_W;
  localparam int CW  = lpdp_pkg::CMP_W;
  localparam int RW  = lpdp_pkg::ROW_W;
  localparam int NS  = lpdp_pkg::NSTG;

  // configuration registers
  logic [lpdp_pkg::CFG_DATA_W-1:0] proj [6];
  logic [lpdp_pkg::CFG_DATA_W-1:0] dist_limits;
  logic [W-1:0]                    image_size;

  logic                  cfg_wr;
  lpdp_pkg::reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = lpdp_pkg::reg_idx_t'(paddr[lpdp_pkg::CFG_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) proj[i] <= '0;
      dist_limits <= '0;
      image_size  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lpdp_pkg::REG_ROW0_LO:     proj[0] <= pwdata;
        lpdp_pkg::REG_ROW0_HI:     proj[1] <= pwdata;
        lpdp_pkg::REG_ROW1_LO:     proj[2] <= pwdata;
        lpdp_pkg::REG_ROW1_HI:     proj[3] <= pwdata;
        lpdp_pkg::REG_ROW2_LO:     proj[4] <= pwdata;
        lpdp_pkg::REG_ROW2_HI:     proj[5] <= pwdata;
        lpdp_pkg::REG_DIST_LIMITS: dist_limits <= pwdata;
        lpdp_pkg::REG_IMAGE_SIZE:  image_size <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lpdp_pkg::REG_ROW0_LO:     prdata = proj[0];
      lpdp_pkg::REG_ROW0_HI:     prdata = proj[1];
      lpdp_pkg::REG_ROW1_LO:     prdata = proj[2];
      lpdp_pkg::REG_ROW1_HI:     prdata = proj[3];
      lpdp_pkg::REG_ROW2_LO:     prdata = proj[4];
      lpdp_pkg::REG_ROW2_HI:     prdata = proj[5];
      lpdp_pkg::REG_DIST_LIMITS: prdata = dist_limits;
      lpdp_pkg::REG_IMAGE_SIZE:  prdata = lpdp_pkg::CFG_DATA_W'(image_size);
      default:                   prdata = '0;
    endcase
  end

  // pipeline control: a stage loads when the output is ready or when it or any stage after it is empty
  lpdp_pkg::stg_mask_t valid;
  lpdp_pkg::stg_mask_t ready;

  always_comb begin
    lpdp_pkg::stg_mask_t low_mask;
    for (int k = 0; k < NS; k++) begin
      low_mask = (lpdp_pkg::stg_mask_t'(1) << k) - lpdp_pkg::stg_mask_t'(1);
      ready[k] = m_tready || ((valid | low_mask) != '1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) valid[0] <= s_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (ready[k]) valid[k] <= valid[k-1];
      end
    end
  end

  assign s_tready = ready[0];
  assign m_tvalid = valid[NS-1];

  // stage 1: twelve products
  lpdp_pkg::prod_t prod1 [3][4];

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod1[r][c] <= lpdp_pkg::smul(proj[2*r + c/2][W*(c%2) +: W], s_tdata[W*c +: W]);
        end
      end
    end
  end

  // stage 2: row sums
  lpdp_pkg::row_t row2 [3];

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      for (int r = 0; r < 3; r++) begin
        row2[r] <= lpdp_pkg::row_sum(prod1[r][0], prod1[r][1], prod1[r][2], prod1[r][3]);
      end
    end
  end

  // stage 3: depth window and image bounds scaled by depth
  lpdp_pkg::cmp_t   depth_ext;
  lpdp_pkg::cmp_t   dmin_ext;
  lpdp_pkg::cmp_t   dmax_ext;
  logic             depth_ok3;
  lpdp_pkg::row_t   row3 [2];
  logic [W-1:0]     depth3;
  logic [DW-1:0]    col_lim3;
  logic [DW-1:0]    row_lim3;

  assign depth_ext = CW'(row2[2]);
  assign dmin_ext  = $signed(CW'(dist_limits[W-1:0]));
  assign dmax_ext  = $signed(CW'(dist_limits[2*W-1:W]));

  always_ff @(posedge clk) begin
    if (ready[2]) begin
      depth_ok3 <= !row2[2][RW-1] && (row2[2] != '0) &&
                   (depth_ext > dmin_ext) && (depth_ext < dmax_ext);
      row3[0]   <= row2[0];
      row3[1]   <= row2[1];
      depth3    <= row2[2][W-1:0];
      col_lim3  <= DW'(image_size[QW-1:0]) * DW'(row2[2][W-1:0]);
      row_lim3  <= DW'(image_size[W-1:QW]) * DW'(row2[2][W-1:0]);
    end
  end

  // stage 4 is divider entry 0, entries 1..DS resolve one quotient bit each
  lpdp_pkg::cmp_t   u_ext;
  lpdp_pkg::cmp_t   v_ext;
  logic             hit4;

  logic             hit_d [DS+1];
  logic [W-1:0]     dvsr  [DS+1];
  logic [DW-1:0]    rem_u [DS+1];
  logic [DW-1:0]    rem_v [DS+1];
  logic [QW-1:0]    q_u   [DS+1];
  logic [QW-1:0]    q_v   [DS+1];

  assign u_ext = CW'(row3[0]);
  assign v_ext = CW'(row3[1]);
  assign hit4  = depth_ok3 &&
                 !row3[0][RW-1] && (row3[0] != '0) &&
                 !row3[1][RW-1] && (row3[1] != '0) &&
                 (u_ext < $signed(CW'(col_lim3))) &&
                 (v_ext < $signed(CW'(row_lim3)));

  always_ff @(posedge clk) begin
    if (ready[3]) begin
      hit_d[0] <= hit4;
      dvsr[0]  <= hit4 ? depth3 : '0;
      rem_u[0] <= hit4 ? u_ext[DW-1:0] : '0;
      rem_v[0] <= hit4 ? v_ext[DW-1:0] : '0;
      q_u[0]   <= '0;
      q_v[0]   <= '0;
    end
  end

  logic [DW-1:0] dsh     [DS+1];
  logic [DW:0]   trial_u [DS+1];
  logic [DW:0]   trial_v [DS+1];
  logic [QW-1:0] qu_next [DS+1];
  logic [QW-1:0] qv_next [DS+1];

  always_comb begin
    dsh[0]     = '0;
    trial_u[0] = '0;
    trial_v[0] = '0;
    qu_next[0] = '0;
    qv_next[0] = '0;
    for (int j = 1; j <= DS; j++) begin
      dsh[j]     = DW'(dvsr[j-1]) << (QW - j);
      trial_u[j] = {1'b0, rem_u[j-1]} - {1'b0, dsh[j]};
      trial_v[j] = {1'b0, rem_v[j-1]} - {1'b0, dsh[j]};
      qu_next[j] = q_u[j-1];
      qv_next[j] = q_v[j-1];
      // a miss divides zero by zero; the hit flag holds its quotient bits clear
      qu_next[j][QW-j] = hit_d[j-1] && !trial_u[j][DW];
      qv_next[j][QW-j] = hit_d[j-1] && !trial_v[j][DW];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 1; j <= DS; j++) begin
      if (ready[3+j]) begin
        hit_d[j] <= hit_d[j-1];
        dvsr[j]  <= dvsr[j-1];
        rem_u[j] <= trial_u[j][DW] ? rem_u[j-1] : trial_u[j][DW-1:0];
        rem_v[j] <= trial_v[j][DW] ? rem_v[j-1] : trial_v[j][DW-1:0];
        q_u[j]   <= qu_next[j];
        q_v[j]   <= qv_next[j];
      end
    end
  end

  // depth rides along as the divisor; it is zero on a miss
  assign m_tdata = {dvsr[DS], q_v[DS], q_u[DS]};
  assign m_tuser = hit_d[DS];

  // a miss carries all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("miss with nonzero payload");

  // a hit always has a positive depth
  a_hit_depth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[lpdp_pkg::OUT_DATA_W-1:2*QW] != '0)
    else $error("hit with zero depth");

  // the divider finished with a proper remainder on both sides
  a_rem_lt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (rem_u[DS] < DW'(dvsr[DS])) && (rem_v[DS] < DW'(dvsr[DS])))
    else $error("divider remainder out of range");

  // input is refused only with every stage full and the output stalled
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (valid == '1) && !m_tready)
    else $error("input refused with room in the pipeline");

  // a full pipeline with the output stalled keeps every stage
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid == '1) && !m_tready |=> valid == '1)
    else $error("stalled pipeline lost a beat");

endmodule

`default_nettype wire

FILE: test/lidar_point_depth_projector_core_test.sv
`default_nettype none

module lidar_point_depth_projector_core_test;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_TAIL = 40;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic        hit;
    logic [15:0] column;
    logic [15:0] row;
    logic [31:0] depth;
  } pixel_t;

  class pixel_scoreboard;
    logic [63:0] cfg_regs [8];
    pixel_t pending_pixels [$];
    int errors;

    function new();
      foreach (cfg_regs[i]) cfg_regs[i] = '0;
      errors = 0;
    endfunction

    function void set_reg(lpdp_pkg::reg_idx_t idx, logic [63:0] value);
      cfg_regs[idx] = (idx == lpdp_pkg::REG_IMAGE_SIZE) ? {32'h0, value[31:0]} : value;
    endfunction

    // each product floored on its own, then the four summed exactly
    function longint project_row(int r, logic [127:0] pt);
      logic [127:0] mw;
      longint acc;
      longint m;
      longint p;
      int c;
      mw = {cfg_regs[2 * r + 1], cfg_regs[2 * r]};
      acc = 0;
      for (c = 0; c < 4; c++) begin
        m = longint'($signed(mw[32 * c +: 32]));
        p = longint'($signed(pt[32 * c +: 32]));
        acc += (m * p) >>> lpdp_pkg::FRAC_BITS;
      end
      return acc;
    endfunction

    function pixel_t project(logic [127:0] pt);
      longint r0;
      longint r1;
      longint r2;
      longint dmin;
      longint dmax;
      longint wd;
      longint ht;
      pixel_t px;
      r0 = project_row(0, pt);
      r1 = project_row(1, pt);
      r2 = project_row(2, pt);
      dmin = longint'(cfg_regs[lpdp_pkg::REG_DIST_LIMITS][31:0]);
      dmax = longint'(cfg_regs[lpdp_pkg::REG_DIST_LIMITS][63:32]);
      wd = longint'(cfg_regs[lpdp_pkg::REG_IMAGE_SIZE][15:0]);
      ht = longint'(cfg_regs[lpdp_pkg::REG_IMAGE_SIZE][31:16]);
      px = '0;
      // depth window first keeps r2 below 2^32 for the bound products
      if (r2 > 0 && r2 > dmin && r2 < dmax && r0 > 0 && r1 > 0 &&
          r0 < wd * r2 && r1 < ht * r2) begin
        px.hit = 1'b1;
        px.column = 16'(r0 / r2);
        px.row = 16'(r1 / r2);
        px.depth = 32'(r2);
      end
      return px;
    endfunction

    function void note_point(logic [127:0] pt);
      pending_pixels.push_back(project(pt));
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("pixel mismatch: %s", what);
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("result with nothing pending: %h", got));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit %b, want %b", got.hit, want.hit));
      if (got.column !== want.column)
        report($sformatf("column %0d, want %0d", got.column, want.column));
      if (got.row !== want.row)
        report($sformatf("row %0d, want %0d", got.row, want.row));
      if (got.depth !== want.depth)
        report($sformatf("depth %h, want %h", got.depth, want.depth));
    endtask
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [lpdp_pkg::CFG_ADDR_W-1:0] paddr;
  logic [lpdp_pkg::CFG_DATA_W-1:0] pwdata;
  logic [lpdp_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;
  logic s_tvalid;
  logic s_tready;
  logic [lpdp_pkg::IN_DATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [lpdp_pkg::OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;

  pixel_scoreboard board = new();
  logic [63:0] cfg_next [8];

  // camera behind the current matrix, used to aim points into the image
  int cam_f;
  int cam_cx;
  int cam_cy;
  int cam_w;
  int cam_h;
  longint cam_min;
  longint cam_max;

  bit src_burst;
  bit sink_burst;
  bit hold_fill;
  bit sink_hold;
  int stall_cycles;

  lidar_point_depth_projector_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [127:0] pack_point(logic [31:0] x, logic [31:0] y,
                                              logic [31:0] z, logic [31:0] w);
    return {w, z, y, x};
  endfunction

  // point aimed at a random pixel and depth of the current camera
  function automatic logic [127:0] aim_point();
    longint z;
    longint u;
    longint v;
    longint x;
    longint y;
    case ($urandom_range(0, 19))
      0: z = cam_min;
      1: z = cam_max;
      2: z = cam_min + 1;
      3: z = cam_max - 1;
      4: z = 0;
      5: z = -longint'($urandom_range(1, 32'h00FF_FFFF));
      default: z = cam_min + 1 + longint'($urandom_range(0, 32'(cam_max - cam_min - 1)));
    endcase
    u = longint'($urandom_range(0, cam_w)) * 65536 + longint'($urandom_range(0, 65535));
    v = longint'($urandom_range(0, cam_h)) * 65536 + longint'($urandom_range(0, 65535));
    if ($urandom_range(0, 15) == 0) u = -u;
    if ($urandom_range(0, 15) == 0) v = -v;
    x = (u - longint'(cam_cx) * 65536) * z / cam_f / 65536;
    y = (v - longint'(cam_cy) * 65536) * z / cam_f / 65536;
    return pack_point(32'(x), 32'(y), 32'(z), ONE);
  endfunction

  function automatic int pick_extent();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 8);
      3: return $urandom_range(1024, 4096);
      default: return $urandom_range(16, 1024);
    endcase
  endfunction

  task automatic send_point(logic [127:0] pt);
    int gap;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    gap = (src_burst || hold_fill) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_point(pt);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic apply_config();
    lpdp_pkg::reg_idx_t idx;
    int i;
    wait_drained();
    for (i = lpdp_pkg::REG_ROW0_LO; i <= lpdp_pkg::REG_IMAGE_SIZE; i++) begin
      idx = lpdp_pkg::reg_idx_t'(i);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= cfg_next[idx];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      board.set_reg(idx, cfg_next[idx]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // focal length on the diagonal, principal point in the third column, optional small skew terms
  task automatic camera_config(bit skew);
    logic [31:0] m [12];
    int i;
    for (i = 0; i < 12; i++) m[i] = skew ? 32'(int'($urandom_range(0, 2048)) - 1024) : 32'h0;
    m[0] = 32'(cam_f) << 16;
    m[2] = 32'(cam_cx) << 16;
    m[5] = 32'(cam_f) << 16;
    m[6] = 32'(cam_cy) << 16;
    m[10] = ONE;
    cfg_next[lpdp_pkg::REG_ROW0_LO] = {m[1], m[0]};
    cfg_next[lpdp_pkg::REG_ROW0_HI] = {m[3], m[2]};
    cfg_next[lpdp_pkg::REG_ROW1_LO] = {m[5], m[4]};
    cfg_next[lpdp_pkg::REG_ROW1_HI] = {m[7], m[6]};
    cfg_next[lpdp_pkg::REG_ROW2_LO] = {m[9], m[8]};
    cfg_next[lpdp_pkg::REG_ROW2_HI] = {m[11], m[10]};
    cfg_next[lpdp_pkg::REG_DIST_LIMITS] = {cam_max[31:0], cam_min[31:0]};
    cfg_next[lpdp_pkg::REG_IMAGE_SIZE] = {32'h0, cam_h[15:0], cam_w[15:0]};
    apply_config();
  endtask

  task automatic random_camera();
    cam_f = $urandom_range(64, 2000);
    cam_w = pick_extent();
    cam_h = pick_extent();
    cam_cx = $urandom_range(0, cam_w);
    cam_cy = $urandom_range(0, cam_h);
    cam_min = $urandom_range(0, 32'h000F_FFFF);
    cam_max = cam_min + $urandom_range(1, 32'h00F0_0000);
    camera_config($urandom_range(0, 1));
  endtask

  // mostly aimed points, some with one field spoiled, the rest raw noise
  task automatic run_phase(int n);
    logic [127:0] pt;
    int r;
    int k;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        pt = aim_point();
      end else if (r < 85) begin
        pt = aim_point();
        pt[32 * $urandom_range(0, 3) +: 32] = $urandom;
      end else begin
        pt = {$urandom, $urandom, $urandom, $urandom};
      end
      send_point(pt);
      if (k == n / 2) wait_drained();
    end
  endtask

  // receiver: random backpressure, bursts, and one long hold on request
  initial begin
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
        gap = sink_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        m_tready <= 1'b1;
        @(posedge clk);
        while (!m_tvalid) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_pixel(pixel_t'({m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[63:32]}));
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    @(posedge clk);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int i;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at reset: zero matrix, nothing can hit
    send_point('0);
    send_point('1);
    send_point(pack_point(32'h0, 32'h0, 32'h000A_0000, ONE));

    // 640x480 camera, f 500, depth window 0.5 to 100.0
    cam_f = 500;
    cam_w = 640;
    cam_h = 480;
    cam_cx = 320;
    cam_cy = 240;
    cam_min = 32'h0000_8000;
    cam_max = 32'h0064_0000;
    camera_config(1'b0);
    send_point(pack_point(32'h0, 32'h0, 32'h000A_0000, ONE));
    send_point(pack_point(32'h0, 32'h0, 32'h0, ONE));
    send_point(pack_point(32'h0, 32'h0, 32'hFFFF_0000, ONE));
    send_point(pack_point(32'h0, 32'h0, 32'h0000_8000, ONE));
    send_point(pack_point(32'h0, 32'h0, 32'h0064_0000, ONE));
    send_point(pack_point(32'h0, 32'h0, 32'h0000_8001, ONE));
    // column and row edges at depth 25.0
    send_point(pack_point(32'hFFF0_0000, 32'h0, 32'h0019_0000, ONE));
    send_point(pack_point(32'hFFF0_0001, 32'h0, 32'h0019_0000, ONE));
    send_point(pack_point(32'h0010_0000, 32'h0, 32'h0019_0000, ONE));
    send_point(pack_point(32'h000F_FFFF, 32'h0, 32'h0019_0000, ONE));
    send_point(pack_point(32'h0, 32'hFFF4_0000, 32'h0019_0000, ONE));
    send_point(pack_point(32'h0, 32'h000C_0000, 32'h0019_0000, ONE));
    send_point(pack_point(32'h0, 32'h000B_FFFF, 32'h0019_0000, ONE));
    send_point(pack_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h000A_0000, ONE));
    send_point(pack_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h000A_0000, ONE));
    send_point(pack_point(32'h0, 32'h0, 32'h7FFF_FFFF, ONE));
    send_point(pack_point(32'h0, 32'h0, 32'h8000_0000, ONE));
    send_point(pack_point(ONE, ONE, ONE, 32'h8000_0000));

    // empty image and empty depth window
    cam_w = 0;
    camera_config(1'b0);
    send_point(pack_point(32'h0, 32'h0, 32'h000A_0000, ONE));
    cam_w = 640;
    cam_h = 0;
    camera_config(1'b0);
    send_point(pack_point(32'h0, 32'h0, 32'h000A_0000, ONE));
    cam_h = 480;
    cam_min = 32'h000A_0000;
    cam_max = 32'h000A_0000;
    camera_config(1'b0);
    send_point(pack_point(32'h0, 32'h0, 32'h000A_0000, ONE));
    cam_max = 32'h0064_0000;

    // all ones everywhere
    for (i = lpdp_pkg::REG_ROW0_LO; i <= lpdp_pkg::REG_DIST_LIMITS; i++) cfg_next[i] = '1;
    cfg_next[lpdp_pkg::REG_IMAGE_SIZE] = {32'h0, 32'hFFFF_FFFF};
    apply_config();
    run_phase(100);

    // largest matrix entries, widest window and image
    for (i = lpdp_pkg::REG_ROW0_LO; i <= lpdp_pkg::REG_ROW2_HI; i++) begin
      cfg_next[i] = {$urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                     $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000};
    end
    cfg_next[lpdp_pkg::REG_DIST_LIMITS] = {32'hFFFF_FFFF, 32'h0};
    cfg_next[lpdp_pkg::REG_IMAGE_SIZE] = {32'h0, 16'hFFFF, 16'hFFFF};
    apply_config();
    run_phase(100);

    // fully random registers
    for (i = lpdp_pkg::REG_ROW0_LO; i <= lpdp_pkg::REG_DIST_LIMITS; i++) begin
      cfg_next[i] = {$urandom, $urandom};
    end
    cfg_next[lpdp_pkg::REG_IMAGE_SIZE] = {32'h0, $urandom};
    apply_config();
    run_phase(100);

    // receiver holds off while points keep coming, so the pipe backs up
    random_camera();
    sink_hold = 1'b1;
    hold_fill = 1'b1;
    run_phase(60);
    hold_fill = 1'b0;

    repeat (9) begin
      random_camera();
      run_phase(170);
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/lpdp_pkg.sv
hdl/lidar_point_depth_projector_core.sv
test/lidar_point_depth_projector_core_test.sv
